// ===== hdl/imu_frame_decode_tilt_defines.svh =====
// Assertion macros shared by the tilt decoder RTL.
`ifndef IMU_FRAME_DECODE_TILT_DEFINES_SVH
`define IMU_FRAME_DECODE_TILT_DEFINES_SVH

// Check a property on every rising edge, held off while reset is high.
`define IFDT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define IFDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/imu_fdt_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_fdt_pkg
// Types, constants and helper functions for the inertial frame tilt decoder.
// ----------------------------------------------------------------------------
package imu_fdt_pkg;

  localparam int FRAME_BYTES  = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_MAX   = 24;
  localparam int STEP_W       = 5;
  localparam int POS_W        = 4;
  localparam int XY_W         = 28;
  localparam int Z_W          = 34;
  localparam int RAD_W        = 48;
  localparam int ROOT_W       = 24;
  localparam int ROOT_CNT_W   = 5;

  localparam logic KIND_BIG    = 1'b0;
  localparam logic KIND_LITTLE = 1'b1;

  localparam logic signed [10:0] ACC_SCALE     = 11'sd1000;
  localparam logic [17:0]        RATE_RECIP_BE = 18'd128071;  // ceil(2^24/131)
  localparam logic [17:0]        RATE_RECIP_LE = 18'd131072;  // 2^24/128
  localparam logic signed [24:0] TEMP_OFFSET   = 25'sd1242020;
  localparam logic signed [24:0] TEMP_SCALE    = 25'sd100;
  localparam logic [20:0]        TEMP_RECIP    = 21'd1579033; // ceil(2^27/85)
  localparam logic [15:0]        CENTI_TURN    = 16'd36000;
  localparam logic [14:0]        PITCH_LIM     = 15'd9000;
  localparam logic [14:0]        ROLL_LIM      = 15'd18000;
  localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sh040000000;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCALE = 9'b000000010,
    S_TMUL  = 9'b000000100,
    S_SQRT  = 9'b000001000,
    S_PITCH = 9'b000010000,
    S_PCONV = 9'b000100000,
    S_ROLL  = 9'b001000000,
    S_RCONV = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [Z_W-1:0]   z;
  } cordic_rsp_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return e[16] ? unsigned'(-e) : unsigned'(e);
  endfunction

  // Truncate raw*1000 / 16384 toward zero.
  function automatic logic signed [11:0] accel_mg(input logic signed [26:0] p);
    logic signed [26:0] a;
    a = p + (p[26] ? 27'sd16383 : 27'sd0);
    return 12'(a >>> 14);
  endfunction

  function automatic logic signed [8:0] rate_dps(input logic [34:0] prod,
                                                 input logic neg);
    logic signed [11:0] q;
    q = signed'({1'b0, prod[34:24]});
    return 9'(neg ? -q : q);
  endfunction

  function automatic logic signed [15:0] to_centi(input logic [49:0] prod,
                                                  input logic neg,
                                                  input logic zero,
                                                  input logic [14:0] lim);
    logic [49:0]        s;
    logic [17:0]        c;
    logic signed [15:0] r;
    s = prod + 50'h0_0000_8000_0000;
    c = 18'(s >> 32);
    if (c > 18'(lim)) begin
      c = 18'(lim);
    end
    r = signed'({1'b0, c[14:0]});
    if (neg) begin
      r = -r;
    end
    if (zero) begin
      r = 16'sd0;
    end
    return r;
  endfunction

endpackage

// ===== hdl/imu_fdt_sqrt.sv =====
// ----------------------------------------------------------------------------
// imu_fdt_sqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module imu_fdt_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [imu_fdt_pkg::RAD_W-1:0]      radicand,
  output logic                               done,
  output logic [imu_fdt_pkg::ROOT_W-1:0]     root
);

  logic                                  busy;
  logic [imu_fdt_pkg::ROOT_CNT_W-1:0]    cnt;
  logic [imu_fdt_pkg::RAD_W-1:0]         rem;
  logic [imu_fdt_pkg::RAD_W-1:0]         res;
  logic [imu_fdt_pkg::RAD_W-1:0]         bitm;
  logic [imu_fdt_pkg::RAD_W-1:0]         trial;

  assign trial = res + bitm;
  assign root  = res[imu_fdt_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == imu_fdt_pkg::ROOT_CNT_W'(imu_fdt_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitm <= imu_fdt_pkg::RAD_W'(1) << (imu_fdt_pkg::RAD_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

// ===== hdl/imu_fdt_cordic.sv =====
// ----------------------------------------------------------------------------
// imu_fdt_cordic
// Vectoring CORDIC, one micro-rotation per cycle on a shared add/shift unit.
// ----------------------------------------------------------------------------
module imu_fdt_cordic #(
  parameter int STEPS = imu_fdt_pkg::CORDIC_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  imu_fdt_pkg::cordic_req_t   req,
  output imu_fdt_pkg::cordic_rsp_t   rsp
);

  logic                                     busy;
  logic                                     done;
  logic [imu_fdt_pkg::STEP_W-1:0]           cnt;
  logic signed [imu_fdt_pkg::XY_W-1:0]      x;
  logic signed [imu_fdt_pkg::XY_W-1:0]      y;
  logic signed [imu_fdt_pkg::Z_W-1:0]       z;
  logic signed [imu_fdt_pkg::XY_W-1:0]      dx;
  logic signed [imu_fdt_pkg::XY_W-1:0]      dy;
  logic signed [imu_fdt_pkg::Z_W-1:0]       dz;

  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign dz = signed'(imu_fdt_pkg::Z_W'(imu_fdt_pkg::atan_step(cnt)));

  assign rsp.done = done;
  assign rsp.z    = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == imu_fdt_pkg::STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= req.x;
      y <= req.y;
      z <= req.z;
    end else if (busy) begin
      // rotate toward the x axis
      if (!y[imu_fdt_pkg::XY_W-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end
    end
  end

endmodule

// ===== hdl/imu_frame_decode_tilt.sv =====
// ----------------------------------------------------------------------------
// imu_frame_decode_tilt
// Collects a 14-byte inertial burst and returns scaled readings plus pitch
// and roll from a shared CORDIC unit.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | in_valid, in_stall, data_byte,  | byte stream in
//          | first_byte                      |
//  out     | out_valid, out_stall, 9 fields  | one transaction per frame
//  cfg     | cfg_we, cfg_wdata               | chip_kind write
//
// A byte that does not close a frame is stored and advances the byte count.
// The closing byte starts the work of the bit-serial square root and the
// shared CORDIC rotator; in_stall stays high for that time, and longer while
// the output register still holds a result that has not been taken.
// A finished result waits in the output register while the next frame's
// bytes are taken. Reset is synchronous and clears the byte count, chip_kind
// and the sequencer.
// ----------------------------------------------------------------------------
`include "imu_frame_decode_tilt_defines.svh"

module imu_frame_decode_tilt #(
  parameter int CORDIC_STEPS = imu_fdt_pkg::CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] accel_x_mg,
  output logic signed [11:0] accel_y_mg,
  output logic signed [11:0] accel_z_mg,
  output logic signed [8:0]  rate_x_dps,
  output logic signed [8:0]  rate_y_dps,
  output logic signed [8:0]  rate_z_dps,
  output logic signed [14:0] temp_centi,
  output logic signed [14:0] pitch_centi,
  output logic signed [15:0] roll_centi
);

  localparam logic [imu_fdt_pkg::POS_W-1:0] LAST_POS =
    imu_fdt_pkg::POS_W'(imu_fdt_pkg::FRAME_BYTES - 1);

  imu_fdt_pkg::state_t state;

  logic                             chip_kind;
  logic                             kind;
  logic [imu_fdt_pkg::POS_W-1:0]    byte_position;
  logic [imu_fdt_pkg::POS_W-1:0]    pos;
  logic [7:0]                       frame_store [imu_fdt_pkg::FRAME_BYTES];
  logic                             in_accept;
  logic                             out_load;

  logic signed [15:0] w_t, w_ax, w_ay, w_az, w_gx, w_gy, w_gz;
  logic signed [31:0] sq_y, sq_z;
  logic [17:0]        rate_recip;

  logic signed [15:0] ax, ay, az;
  logic [31:0]        sumsq;
  logic signed [26:0] acc_px, acc_py, acc_pz;
  logic [34:0]        rate_px, rate_py, rate_pz;
  logic               rate_nx, rate_ny, rate_nz;
  logic signed [24:0] temp_num;
  logic [24:0]        temp_mag;
  logic [24:0]        temp_mag_next;
  logic               temp_neg;
  logic [41:0]        temp_prod;
  logic [13:0]        temp_q;
  logic signed [14:0] temp_s;

  logic                           sqrt_start;
  logic                           sqrt_done;
  logic [imu_fdt_pkg::ROOT_W-1:0] root;

  imu_fdt_pkg::cordic_req_t       creq;
  imu_fdt_pkg::cordic_rsp_t       crsp;
  logic signed [imu_fdt_pkg::XY_W-1:0] sy, sz;
  logic [imu_fdt_pkg::Z_W-1:0]    zmag;
  logic [49:0]                    cent_prod;
  logic                           cent_neg;
  logic                           pitch_zero, roll_zero;
  logic signed [15:0]             pitch_val, roll_val;
  logic signed [15:0]             pitch_r, roll_r;

  assign in_stall  = (state != imu_fdt_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == imu_fdt_pkg::S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    pos = first_byte ? '0 : byte_position;
    if (pos > LAST_POS) begin
      pos = '0;
    end
  end

  // word decode: little-endian puts the low byte first
  always_comb begin
    if (kind == imu_fdt_pkg::KIND_LITTLE) begin
      w_t  = signed'({frame_store[1],  frame_store[0]});
      w_ax = signed'({frame_store[3],  frame_store[2]});
      w_ay = signed'({frame_store[5],  frame_store[4]});
      w_az = signed'({frame_store[7],  frame_store[6]});
      w_gx = signed'({frame_store[9],  frame_store[8]});
      w_gy = signed'({frame_store[11], frame_store[10]});
      w_gz = signed'({frame_store[13], frame_store[12]});
      rate_recip = imu_fdt_pkg::RATE_RECIP_LE;
    end else begin
      w_ax = signed'({frame_store[0],  frame_store[1]});
      w_ay = signed'({frame_store[2],  frame_store[3]});
      w_az = signed'({frame_store[4],  frame_store[5]});
      w_t  = signed'({frame_store[6],  frame_store[7]});
      w_gx = signed'({frame_store[8],  frame_store[9]});
      w_gy = signed'({frame_store[10], frame_store[11]});
      w_gz = signed'({frame_store[12], frame_store[13]});
      rate_recip = imu_fdt_pkg::RATE_RECIP_BE;
    end
  end

  assign sq_y = w_ay * w_ay;
  assign sq_z = w_az * w_az;
  assign temp_mag_next = temp_num[24] ? unsigned'(-temp_num) : unsigned'(temp_num);

  assign sy = imu_fdt_pkg::XY_W'(ay) <<< 8;
  assign sz = imu_fdt_pkg::XY_W'(az) <<< 8;
  assign zmag = crsp.z[imu_fdt_pkg::Z_W-1] ? unsigned'(-crsp.z) : unsigned'(crsp.z);
  assign pitch_val = imu_fdt_pkg::to_centi(cent_prod, cent_neg, pitch_zero,
                                           imu_fdt_pkg::PITCH_LIM);
  assign roll_val  = imu_fdt_pkg::to_centi(cent_prod, cent_neg, roll_zero,
                                           imu_fdt_pkg::ROLL_LIM);

  always_comb begin
    if (kind == imu_fdt_pkg::KIND_LITTLE) begin
      temp_q = 14'((temp_mag + 25'd128) >> 8);
    end else begin
      temp_q = 14'(temp_prod >> 27);
    end
    temp_s = signed'({1'b0, temp_q});
    if (temp_neg) begin
      temp_s = -temp_s;
    end
  end

  // CORDIC requests for pitch and, from the pitch conversion, for roll
  always_comb begin
    creq = '0;
    if (state == imu_fdt_pkg::S_SQRT && sqrt_done) begin
      creq.start = 1'b1;
      creq.x     = imu_fdt_pkg::XY_W'(root);
      creq.y     = imu_fdt_pkg::XY_W'(ax) <<< 8;
    end else if (state == imu_fdt_pkg::S_PCONV) begin
      creq.start = 1'b1;
      if (!az[15]) begin
        creq.x = sz;
        creq.y = sy;
      end else if (!ay[15]) begin
        creq.x = sy;
        creq.y = -sz;
        creq.z = imu_fdt_pkg::QUARTER_TURN;
      end else begin
        creq.x = -sy;
        creq.y = sz;
        creq.z = -imu_fdt_pkg::QUARTER_TURN;
      end
    end
  end

  assign sqrt_start = (state == imu_fdt_pkg::S_TMUL);

  imu_fdt_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({sumsq, 16'h0000}),
    .done     (sqrt_done),
    .root     (root)
  );

  imu_fdt_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_store[pos] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= imu_fdt_pkg::S_IDLE;
      byte_position <= '0;
      chip_kind     <= imu_fdt_pkg::KIND_BIG;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        chip_kind <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        imu_fdt_pkg::S_IDLE: begin
          if (in_accept) begin
            if (pos == LAST_POS) begin
              byte_position <= '0;
              state         <= imu_fdt_pkg::S_SCALE;
            end else begin
              byte_position <= pos + 1'b1;
            end
          end
        end
        imu_fdt_pkg::S_SCALE: state <= imu_fdt_pkg::S_TMUL;
        imu_fdt_pkg::S_TMUL:  state <= imu_fdt_pkg::S_SQRT;
        imu_fdt_pkg::S_SQRT: begin
          if (sqrt_done) begin
            state <= imu_fdt_pkg::S_PITCH;
          end
        end
        imu_fdt_pkg::S_PITCH: begin
          if (crsp.done) begin
            state <= imu_fdt_pkg::S_PCONV;
          end
        end
        imu_fdt_pkg::S_PCONV: state <= imu_fdt_pkg::S_ROLL;
        imu_fdt_pkg::S_ROLL: begin
          if (crsp.done) begin
            state <= imu_fdt_pkg::S_RCONV;
          end
        end
        imu_fdt_pkg::S_RCONV: state <= imu_fdt_pkg::S_OUT;
        imu_fdt_pkg::S_OUT: begin
          if (out_load) begin
            state <= imu_fdt_pkg::S_IDLE;
          end
        end
        default: state <= imu_fdt_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept && pos == LAST_POS) begin
      kind <= chip_kind;
    end
    if (state == imu_fdt_pkg::S_SCALE) begin
      ax       <= w_ax;
      ay       <= w_ay;
      az       <= w_az;
      sumsq    <= unsigned'(sq_y) + unsigned'(sq_z);
      acc_px   <= w_ax * imu_fdt_pkg::ACC_SCALE;
      acc_py   <= w_ay * imu_fdt_pkg::ACC_SCALE;
      acc_pz   <= w_az * imu_fdt_pkg::ACC_SCALE;
      rate_px  <= 35'(imu_fdt_pkg::mag16(w_gx)) * 35'(rate_recip);
      rate_py  <= 35'(imu_fdt_pkg::mag16(w_gy)) * 35'(rate_recip);
      rate_pz  <= 35'(imu_fdt_pkg::mag16(w_gz)) * 35'(rate_recip);
      rate_nx  <= w_gx[15];
      rate_ny  <= w_gy[15];
      rate_nz  <= w_gz[15];
      if (kind == imu_fdt_pkg::KIND_LITTLE) begin
        temp_num <= 25'(w_t) * imu_fdt_pkg::TEMP_SCALE;
      end else begin
        temp_num <= 25'(w_t) * imu_fdt_pkg::TEMP_SCALE + imu_fdt_pkg::TEMP_OFFSET;
      end
    end
    if (state == imu_fdt_pkg::S_TMUL) begin
      // round half away: (|n| + 170) / 340 == ((|n| + 170) >> 2) / 85
      temp_mag  <= temp_mag_next;
      temp_neg  <= temp_num[24];
      temp_prod <= 42'((temp_mag_next + 25'd170) >> 2) * 42'(imu_fdt_pkg::TEMP_RECIP);
    end
    if (state == imu_fdt_pkg::S_SQRT && sqrt_done) begin
      pitch_zero <= (root == '0) && (ax == 16'sd0);
      roll_zero  <= (ay == 16'sd0) && (az == 16'sd0);
    end
    if ((state == imu_fdt_pkg::S_PITCH || state == imu_fdt_pkg::S_ROLL) && crsp.done) begin
      cent_prod <= 50'(zmag) * 50'(imu_fdt_pkg::CENTI_TURN);
      cent_neg  <= crsp.z[imu_fdt_pkg::Z_W-1];
    end
    if (state == imu_fdt_pkg::S_PCONV) begin
      pitch_r <= pitch_val;
    end
    if (state == imu_fdt_pkg::S_RCONV) begin
      roll_r <= roll_val;
    end
    if (out_load) begin
      accel_x_mg  <= imu_fdt_pkg::accel_mg(acc_px);
      accel_y_mg  <= imu_fdt_pkg::accel_mg(acc_py);
      accel_z_mg  <= imu_fdt_pkg::accel_mg(acc_pz);
      rate_x_dps  <= imu_fdt_pkg::rate_dps(rate_px, rate_nx);
      rate_y_dps  <= imu_fdt_pkg::rate_dps(rate_py, rate_ny);
      rate_z_dps  <= imu_fdt_pkg::rate_dps(rate_pz, rate_nz);
      temp_centi  <= temp_s;
      pitch_centi <= 15'(pitch_r);
      roll_centi  <= roll_r;
    end
  end

  `IFDT_ASSERT(a_pos_range, clk, rst, byte_position <= LAST_POS, "byte position past frame end")
  `IFDT_ASSERT(a_last_byte_starts, clk, rst, (in_accept && pos == LAST_POS) |=> (state == imu_fdt_pkg::S_SCALE), "closing byte did not start decode")
  `IFDT_ASSERT(a_out_load, clk, rst, (state == imu_fdt_pkg::S_OUT && !out_valid) |=> (out_valid && state == imu_fdt_pkg::S_IDLE), "result not handed to output")
  `IFDT_ASSERT_ALWAYS(a_no_out_in_flight, clk, (state != imu_fdt_pkg::S_IDLE && state != imu_fdt_pkg::S_OUT) |-> !out_load, "output loaded mid-computation")

endmodule
